// ===== hw/rtl/fdp_pkg.sv =====
// Shared constants and types of the decimal format printer.
package fdp_pkg;

    // ASCII codes the formatter recognizes or produces
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // Binary to BCD conversion geometry
    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PCT   = 6'b000010,
        ST_PLAIN = 6'b000100,
        ST_MINUS = 6'b001000,
        ST_CONV  = 6'b010000,
        ST_DIGIT = 6'b100000
    } t_state;

    // Control between sequencer and conversion unit
    typedef struct packed {
        logic start;
    } t_conv_ctrl;

    typedef struct packed {
        logic busy;
    } t_conv_stat;

endpackage

// ===== hw/rtl/fdp_in_if.sv =====
// Input channel: format byte plus argument, valid/ready handshake.
interface fdp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fmt_char;
    logic signed [31:0] arg_value;

    modport source (output valid, output fmt_char, output arg_value, input ready);
    modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

// ===== hw/rtl/fdp_out_if.sv =====
// Output channel: one emitted character, valid/ready handshake.
interface fdp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== hw/rtl/fdp_bcd_conv.sv =====
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
module fdp_bcd_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fdp_pkg::t_conv_ctrl         i_ctrl,
    input  logic [fdp_pkg::BIN_W-1:0]   i_value,
    output fdp_pkg::t_conv_stat         o_stat,
    output logic [fdp_pkg::BCD_W-1:0]   o_bcd
);

    logic                       r_busy;
    logic [fdp_pkg::CNT_W-1:0]  r_cnt;
    logic [fdp_pkg::BIN_W-1:0]  r_bin;
    logic [fdp_pkg::BCD_W-1:0]  r_bcd;
    logic [fdp_pkg::BCD_W-1:0]  w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < fdp_pkg::NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // control: busy from start until all BIN_W bits have been shifted in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + fdp_pkg::CNT_W'(1);
            if (r_cnt == fdp_pkg::CNT_W'(fdp_pkg::BIN_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: shift the next binary bit into the digit register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[fdp_pkg::BIN_W-2:0], 1'b0};
            r_bcd <= {w_adj[fdp_pkg::BCD_W-2:0], r_bin[fdp_pkg::BIN_W-1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_bcd       = r_bcd;

endmodule

// ===== hw/rtl/format_decimal_printer.sv =====
// Top level: printf-style formatter for %d and %i with a serial character output.
//
//  Channel  Dir  Fields               Transfer
//  i_in     in   fmt_char, arg_value  valid & ready
//  o_out    out  out_char, run_last   valid & ready
//
// A literal byte is accepted and then emits its character, if any ('%' flush
// adds one). A %d/%i starts the BCD unit, which converts one bit per cycle;
// the digits are then loaded and emitted, leading zeros skipped one per
// cycle, and a minus sign goes out first, often while the conversion runs.
// Reset (synchronous, active low) clears the pending '%' and the sequencer.
// A stalled output holds the sequencer in any state that emits; the last character may wait in the
// output register while the next byte is taken.
module format_decimal_printer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdp_in_if.sink        i_in,
    fdp_out_if.source     o_out
);

    fdp_pkg::t_state                 r_state, n_state;
    logic                            r_pend, n_pend;
    logic [7:0]                      r_char, n_char;
    logic                            r_neg, n_neg;
    logic [fdp_pkg::BCD_W-1:0]       r_bcd, n_bcd;
    logic [fdp_pkg::LEFT_W-1:0]      r_left, n_left;
    logic                            r_sig, n_sig;

    logic                            r_out_valid;
    logic [7:0]                      r_out_char;
    logic                            r_out_last;

    logic                            w_accept;
    logic                            w_is_dec;
    logic                            w_slot;
    logic                            w_emit;
    logic [7:0]                      w_emit_char;
    logic                            w_emit_last;
    logic [3:0]                      w_top;
    logic [fdp_pkg::BIN_W-1:0]       w_mag;
    logic [fdp_pkg::BCD_W-1:0]       w_conv_bcd;
    fdp_pkg::t_conv_ctrl             w_conv_ctrl;
    fdp_pkg::t_conv_stat             w_conv_stat;

    assign i_in.ready = (r_state == fdp_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_dec   = r_pend && (i_in.fmt_char == fdp_pkg::CH_D ||
                                   i_in.fmt_char == fdp_pkg::CH_I);
    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_top      = r_bcd[fdp_pkg::BCD_W-1 -: 4];

    // magnitude as unsigned negation, so the most negative value survives
    assign w_mag = i_in.arg_value[fdp_pkg::BIN_W-1] ?
                   (fdp_pkg::BIN_W'(0) - fdp_pkg::BIN_W'(i_in.arg_value)) :
                   fdp_pkg::BIN_W'(i_in.arg_value);

    assign w_conv_ctrl.start = w_accept && w_is_dec;

    fdp_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_conv_ctrl),
        .i_value (w_mag),
        .o_stat  (w_conv_stat),
        .o_bcd   (w_conv_bcd)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_char      = r_char;
        n_neg       = r_neg;
        n_bcd       = r_bcd;
        n_left      = r_left;
        n_sig       = r_sig;
        w_emit      = 1'b0;
        w_emit_char = r_char;
        w_emit_last = 1'b0;
        unique case (r_state)
            fdp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_char = i_in.fmt_char;
                    if (w_is_dec) begin
                        n_pend  = 1'b0;
                        n_neg   = i_in.arg_value[fdp_pkg::BIN_W-1];
                        n_state = i_in.arg_value[fdp_pkg::BIN_W-1] ?
                                  fdp_pkg::ST_MINUS : fdp_pkg::ST_CONV;
                    end else if (r_pend) begin
                        n_pend  = 1'b0;
                        n_state = fdp_pkg::ST_PCT;
                    end else if (i_in.fmt_char == fdp_pkg::CH_NUL) begin
                        n_pend = 1'b0;
                    end else if (i_in.fmt_char == fdp_pkg::CH_PERCENT) begin
                        n_pend = 1'b1;
                    end else begin
                        n_state = fdp_pkg::ST_PLAIN;
                    end
                end
            end
            fdp_pkg::ST_PCT: begin
                // flushed '%'; a held NUL ends, a held '%' pends again, else handled as plain
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = fdp_pkg::CH_PERCENT;
                    if (r_char == fdp_pkg::CH_NUL) begin
                        w_emit_last = 1'b1;
                        n_state     = fdp_pkg::ST_IDLE;
                    end else if (r_char == fdp_pkg::CH_PERCENT) begin
                        w_emit_last = 1'b1;
                        n_pend      = 1'b1;
                        n_state     = fdp_pkg::ST_IDLE;
                    end else begin
                        n_state = fdp_pkg::ST_PLAIN;
                    end
                end
            end
            fdp_pkg::ST_PLAIN: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    n_state     = fdp_pkg::ST_IDLE;
                end
            end
            fdp_pkg::ST_MINUS: begin
                if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = fdp_pkg::CH_MINUS;
                    n_state     = fdp_pkg::ST_CONV;
                end
            end
            fdp_pkg::ST_CONV: begin
                if (!w_conv_stat.busy) begin
                    n_bcd   = w_conv_bcd;
                    n_left  = fdp_pkg::LEFT_W'(fdp_pkg::NUM_DIGITS);
                    n_sig   = 1'b0;
                    n_state = fdp_pkg::ST_DIGIT;
                end
            end
            fdp_pkg::ST_DIGIT: begin
                // drop leading zeros, always keep the units digit
                if (w_top == 4'd0 && !r_sig && r_left != fdp_pkg::LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[fdp_pkg::BCD_W-5:0], 4'd0};
                    n_left = r_left - fdp_pkg::LEFT_W'(1);
                end else if (w_slot) begin
                    w_emit      = 1'b1;
                    w_emit_char = fdp_pkg::CH_ZERO + {4'd0, w_top};
                    w_emit_last = (r_left == fdp_pkg::LEFT_W'(1));
                    n_bcd       = {r_bcd[fdp_pkg::BCD_W-5:0], 4'd0};
                    n_left      = r_left - fdp_pkg::LEFT_W'(1);
                    n_sig       = 1'b1;
                    if (r_left == fdp_pkg::LEFT_W'(1)) begin
                        n_state = fdp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = fdp_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdp_pkg::ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_neg  <= n_neg;
        r_bcd  <= n_bcd;
        r_left <= n_left;
        r_sig  <= n_sig;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.run_last = r_out_last;

    // checks
    a_digit_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fdp_pkg::ST_DIGIT |-> !w_conv_stat.busy)
        else $error("digit emission while conversion still running");

    a_dec_starts_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_dec |=> w_conv_stat.busy)
        else $error("decimal specifier did not start the converter");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_emit_last |=> r_state == fdp_pkg::ST_IDLE)
        else $error("final character did not return the sequencer to idle");

    a_minus_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fdp_pkg::ST_MINUS |-> r_neg)
        else $error("minus sign emitted for a non-negative argument");

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_slot)
        else $error("character emitted over an untaken result");

endmodule

// ===== bench/format_decimal_printer_test.sv =====
// Self-checking testbench of the %d/%i format printer: directed table, then random strings.
module format_decimal_printer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 225;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_N          = 25;

    // One emitted character as the output channel should show it
    typedef struct {
        logic [7:0] out_char;
        logic       run_last;
    } t_char_exp;

    // Directed row; text is right-aligned ASCII, used only when has_text is set
    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [31:0] arg_value;
        logic        has_text;
        logic [87:0] text;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fdp_in_if  in_ch ();
    fdp_out_if out_ch ();

    format_decimal_printer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Printer model state and the characters still owed by the block
    logic       pct_pending;
    logic [7:0] printed_text[$];
    t_char_exp  expected_chars[$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int convs_sent     = 0;
    int chars_checked  = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int stall_timer    = 0;

    t_dir_row directed_rows [DIR_N] = '{
        '{"A",                 32'd0,          1'b1, "A"},
        '{fdp_pkg::CH_D,       32'd5,          1'b1, "d"},
        '{fdp_pkg::CH_I,       32'hFFFF_FFFF,  1'b1, "i"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_D,       32'd0,          1'b1, "0"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_I,       32'h8000_0000,  1'b1, "-2147483648"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_D,       32'h7FFF_FFFF,  1'b1, "2147483647"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_I,       32'hFFFF_FFFF,  1'b1, "-1"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, "%"},
        '{"x",                 32'd0,          1'b1, "%x"},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_NUL,     32'd0,          1'b1, "%"},
        '{fdp_pkg::CH_NUL,     32'd0,          1'b1, ""},
        '{8'hFF,               32'hFFFF_FFFF,  1'b0, ""},
        '{fdp_pkg::CH_PERCENT, 32'hFFFF_FFFF,  1'b1, ""},
        '{8'h80,               32'd0,          1'b0, ""},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_D,       32'd1000000000, 1'b0, ""},
        '{fdp_pkg::CH_PERCENT, 32'd0,          1'b1, ""},
        '{fdp_pkg::CH_I,       32'd9,          1'b1, "9"},
        '{fdp_pkg::CH_NUL,     32'd0,          1'b1, ""}
    };

    // Printer model: text caused by one format byte, updates the pending '%'
    function automatic void format_byte(input logic [7:0] c, input logic [31:0] arg);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        logic        literal;
        printed_text.delete();
        literal = 1'b1;
        if (pct_pending) begin
            pct_pending = 1'b0;
            if (c == fdp_pkg::CH_D || c == fdp_pkg::CH_I) begin
                literal = 1'b0;
                mag = arg;
                if (arg[31]) begin
                    printed_text.push_back(fdp_pkg::CH_MINUS);
                    mag = 32'd0 - arg;
                end
                do begin
                    digits.push_front(fdp_pkg::CH_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 32'd0);
                foreach (digits[k]) printed_text.push_back(digits[k]);
            end else begin
                printed_text.push_back(fdp_pkg::CH_PERCENT);
            end
        end
        if (literal) begin
            if (c == fdp_pkg::CH_NUL)
                pct_pending = 1'b0;
            else if (c == fdp_pkg::CH_PERCENT)
                pct_pending = 1'b1;
            else
                printed_text.push_back(c);
        end
    endfunction

    // Argument mix: full range, small values, extremes, powers of ten, right-shifted random values
    function automatic logic [31:0] pick_arg();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: return 32'd0 - $urandom_range(1, 99);
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
            4: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                if ($urandom_range(0, 1)) p = p - 32'd1;
                return $urandom_range(0, 1) ? p : 32'd0 - p;
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Offer one byte in bursts with random gaps, then queue what it should print
    task automatic send_byte(input logic [7:0] c, input logic [31:0] arg,
                             input logic has_text, input logic [87:0] text);
        int gap;
        logic [7:0] ch;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.fmt_char  <= c;
        in_ch.arg_value <= arg;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        bytes_sent++;
        if (pct_pending && (c == fdp_pkg::CH_D || c == fdp_pkg::CH_I)) convs_sent++;
        format_byte(c, arg);
        if (has_text) begin
            printed_text.delete();
            for (int k = 10; k >= 0; k--) begin
                ch = text[k*8 +: 8];
                if (ch != 8'h00) printed_text.push_back(ch);
            end
        end
        foreach (printed_text[k])
            expected_chars.push_back('{printed_text[k], k == printed_text.size() - 1});
    endtask

    // Output side: check each transfer, stall on a pattern, watch for a hang
    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    $error("unexpected character %h", out_ch.out_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_char !== want.out_char) begin
                        mismatch_count++;
                        $error("out_char: expected %h, got %h",
                               want.out_char, out_ch.out_char);
                    end
                    if (out_ch.run_last !== want.run_last) begin
                        mismatch_count++;
                        $error("run_last: expected %b, got %b",
                               want.run_last, out_ch.run_last);
                    end
                end
            end

            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end

            // stall modes: always ready, mostly ready, mostly stalled, alternating
            if (stall_timer == 0) begin
                stall_mode  = $urandom_range(0, 3);
                stall_timer = $urandom_range(10, 80);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 3) != 0;
                2: out_ch.ready <= $urandom_range(0, 3) == 0;
                default: out_ch.ready <= ~out_ch.ready;
            endcase
        end
    end

    // Stimulus: reset, directed table, random format strings, drain
    initial begin
        logic [7:0] c;
        int kind;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.fmt_char  <= fdp_pkg::CH_NUL;
        in_ch.arg_value <= 32'd0;
        pct_pending      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_byte(directed_rows[r].fmt_char, directed_rows[r].arg_value,
                      directed_rows[r].has_text, directed_rows[r].text);

        // mostly well-formed text with conversions; some broken '%' and raw bytes
        while (bytes_sent < DIR_N + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                send_byte(fdp_pkg::CH_PERCENT, $urandom, 1'b0, '0);
                send_byte($urandom_range(0, 1) ? fdp_pkg::CH_D : fdp_pkg::CH_I,
                          pick_arg(), 1'b0, '0);
            end else if (kind < 14) begin
                send_byte(8'($urandom_range(8'h20, 8'h7E)), $urandom, 1'b0, '0);
            end else if (kind < 16) begin
                send_byte(fdp_pkg::CH_NUL, $urandom, 1'b0, '0);
            end else if (kind < 18) begin
                c = 8'($urandom_range(0, 255));
                if (c == fdp_pkg::CH_D || c == fdp_pkg::CH_I) c = fdp_pkg::CH_PERCENT;
                send_byte(fdp_pkg::CH_PERCENT, $urandom, 1'b0, '0);
                send_byte(c, $urandom, 1'b0, '0);
            end else begin
                send_byte(8'($urandom_range(0, 255)), $urandom, 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d format bytes including %0d conversions", bytes_sent, convs_sent);
        $display("checked %0d output characters under random stalls", chars_checked);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
